// ===== hdl/lkvc_pkg.sv =====
`default_nettype none
package lkvc_pkg;

  localparam int unsigned MAX_ENTRIES_DEF = 16;

  // command codes
  localparam logic CMD_GET = 1'b0;
  localparam logic CMD_SET = 1'b1;

  // APB register map
  localparam int unsigned PADDR_W = 3;
  localparam int unsigned REG_IDX_W = PADDR_W - 2;
  localparam logic [REG_IDX_W-1:0] REG_CAPACITY = '0;
  localparam logic [4:0] CAPACITY_RESET = 5'd16;

  localparam logic signed [31:0] MISS_VALUE = '1;

  typedef struct packed {
    logic               command;
    logic signed [31:0] key;
    logic signed [31:0] value;
  } req_t;

  typedef struct packed {
    logic               hit;
    logic signed [31:0] read_value;
  } rsp_t;

endpackage
`default_nettype wire

// ===== hdl/lkvc_if.sv =====
`default_nettype none
interface lkvc_req_if;
  logic               valid;
  logic               ready;
  logic               command;
  logic signed [31:0] key;
  logic signed [31:0] value;

  modport source (output valid, output command, output key, output value, input ready);
  modport sink   (input valid, input command, input key, input value, output ready);
endinterface

interface lkvc_rsp_if;
  logic               valid;
  logic               ready;
  logic               hit;
  logic signed [31:0] read_value;

  modport source (output valid, output hit, output read_value, input ready);
  modport sink   (input valid, input hit, input read_value, output ready);
endinterface
`default_nettype wire

// ===== hdl/lkvc_core.sv =====
`default_nettype none
module lkvc_core #(
  parameter int unsigned MAX_ENTRIES = lkvc_pkg::MAX_ENTRIES_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire lkvc_pkg::req_t req_in,
  input  wire logic [4:0]    capacity,
  input  wire logic          take,
  output logic               idle,
  output logic               done,
  output lkvc_pkg::rsp_t     rsp_out
);
  import lkvc_pkg::*;

  localparam int unsigned IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_DECIDE, S_PROMOTE, S_DONE
  } state_t;

  state_t state;

  // storage
  logic [63:0]         kv_mem   [MAX_ENTRIES];
  logic [IW-1:0]       rank_mem [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] valid;
  logic [CW-1:0]       count;

  // sweep pointer and registered read pipeline
  logic [CW-1:0]       ptr;
  logic                rd_vld;
  logic [IW-1:0]       rd_idx;
  logic [63:0]         kv_q;
  logic [IW-1:0]       rank_q;

  req_t                cur;

  // scan results
  logic                m_found, v_found, f_found;
  logic [IW-1:0]       m_idx, v_idx, f_idx;
  logic [IW-1:0]       m_rank, v_rank;
  logic [31:0]         m_val;

  // promote job
  logic [IW-1:0]       tgt;
  logic [IW-1:0]       old_rank;
  logic                age_all;

  logic                issue_more;
  logic [IW-1:0]       rd_addr;
  logic [31:0]         eff_cap;
  logic                full;

  logic                dec_write, dec_promote, dec_insert, dec_all;
  logic [IW-1:0]       dec_slot, dec_old;

  logic                rank_we;
  logic [IW-1:0]       rank_wd;

  assign rd_addr    = ptr[IW-1:0];
  assign issue_more = 32'(ptr) < 32'(MAX_ENTRIES);

  // capacity 0 acts as 1, anything over the store depth saturates
  always_comb begin
    if (capacity == '0) begin
      eff_cap = 32'd1;
    end else if (32'(capacity) > 32'(MAX_ENTRIES)) begin
      eff_cap = 32'(MAX_ENTRIES);
    end else begin
      eff_cap = 32'(capacity);
    end
  end
  assign full = 32'(count) >= eff_cap;

  always_comb begin
    dec_write   = 1'b0;
    dec_promote = 1'b0;
    dec_insert  = 1'b0;
    dec_all     = 1'b0;
    dec_slot    = m_idx;
    dec_old     = m_rank;
    if (m_found) begin
      dec_write   = (cur.command == CMD_SET);
      dec_promote = 1'b1;
    end else if (cur.command == CMD_SET) begin
      if (full && v_found) begin
        dec_write   = 1'b1;
        dec_promote = 1'b1;
        dec_slot    = v_idx;
        dec_old     = v_rank;
      end else if (f_found) begin
        dec_write   = 1'b1;
        dec_promote = 1'b1;
        dec_insert  = 1'b1;
        dec_all     = 1'b1;
        dec_slot    = f_idx;
      end
    end
  end

  // rank update: target goes to 0, younger valid entries (all of them on an insert) age by one
  always_comb begin
    rank_we = 1'b0;
    rank_wd = rank_q + 1'b1;
    if (state == S_PROMOTE && rd_vld) begin
      if (rd_idx == tgt) begin
        rank_we = 1'b1;
        rank_wd = '0;
      end else if (valid[rd_idx] && (age_all || rank_q < old_rank)) begin
        rank_we = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    kv_q   <= kv_mem[rd_addr];
    rank_q <= rank_mem[rd_addr];
    if (state == S_DECIDE && dec_write) begin
      kv_mem[dec_slot] <= {cur.key, cur.value};
    end
    if (rank_we) begin
      rank_mem[rd_idx] <= rank_wd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      valid  <= '0;
      count  <= '0;
      ptr    <= '0;
      rd_vld <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (start) begin
            cur     <= req_in;
            m_found <= 1'b0;
            v_found <= 1'b0;
            f_found <= 1'b0;
            ptr     <= '0;
            rd_vld  <= 1'b0;
            state   <= S_SCAN;
          end
        end
        S_SCAN, S_PROMOTE: begin
          rd_vld <= issue_more;
          rd_idx <= rd_addr;
          if (issue_more) begin
            ptr <= ptr + 1'b1;
          end
          if (state == S_SCAN && rd_vld) begin
            if (valid[rd_idx] && kv_q[63:32] == cur.key && !m_found) begin
              m_found <= 1'b1;
              m_idx   <= rd_idx;
              m_rank  <= rank_q;
              m_val   <= kv_q[31:0];
            end
            if (valid[rd_idx] && (!v_found || rank_q > v_rank)) begin
              v_found <= 1'b1;
              v_idx   <= rd_idx;
              v_rank  <= rank_q;
            end
            if (!valid[rd_idx] && !f_found) begin
              f_found <= 1'b1;
              f_idx   <= rd_idx;
            end
          end
          if (!issue_more && rd_vld) begin
            state <= (state == S_SCAN) ? S_DECIDE : S_DONE;
          end
        end
        S_DECIDE: begin
          rsp_out.hit        <= m_found;
          rsp_out.read_value <= (cur.command == CMD_GET && m_found) ?
                                signed'(m_val) : MISS_VALUE;
          tgt      <= dec_slot;
          old_rank <= dec_old;
          age_all  <= dec_all;
          ptr      <= '0;
          rd_vld   <= 1'b0;
          if (dec_insert) begin
            valid[dec_slot] <= 1'b1;
            count           <= count + 1'b1;
          end
          state <= dec_promote ? S_PROMOTE : S_DONE;
        end
        S_DONE: begin
          if (take) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign idle = (state == S_IDLE);
  assign done = (state == S_DONE);

endmodule
`default_nettype wire

// ===== hdl/lru_key_value_cache.sv =====
// Channel  Dir  Handshake      Word
// -------  ---  -------------  ----------------------------------------
// req      in   valid/ready    command (0 get, 1 set), key, value
// rsp      out  valid/ready    hit, read_value (-1 on get miss or set)
// apb      in   psel/penable   capacity_in_use at byte address 0
//
// One word at a time. A request scans all MAX_ENTRIES slots through one
// read port, decides, and on a hit or a set runs a second sweep over the
// rank memory; a get miss goes straight to rsp. The sweeps set the time
// from accept to rsp valid.
// rst is synchronous: valid bits, fill count and capacity (16) reset;
// key, value and rank memories are not cleared.
// A finished response sits in the rsp register; the next request is taken
// while it waits, and its own response holds in the core until rsp drains.
`default_nettype none
module lru_key_value_cache #(
  parameter int unsigned MAX_ENTRIES = lkvc_pkg::MAX_ENTRIES_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  lkvc_req_if.sink                          req,
  lkvc_rsp_if.source                        rsp,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [lkvc_pkg::PADDR_W-1:0] paddr,
  input  wire logic [31:0]                  pwdata,
  output logic      [31:0]                  prdata,
  output logic                              pready
);
  import lkvc_pkg::*;

  logic [4:0] capacity;
  logic       reg_sel;

  req_t core_req;
  rsp_t core_rsp;
  rsp_t rsp_q;
  logic rsp_valid;
  logic core_idle, core_done, take;

  // register file: one register, upper address bits pick it
  assign pready  = 1'b1;
  assign reg_sel = (paddr[PADDR_W-1:2] == REG_CAPACITY);
  assign prdata  = reg_sel ? {27'd0, capacity} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAPACITY_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      capacity <= pwdata[4:0];
    end
  end

  // request side
  assign req.ready        = core_idle;
  assign core_req.command = req.command;
  assign core_req.key     = req.key;
  assign core_req.value   = req.value;

  // response register frees the core as soon as it can hand over
  assign take = !rsp_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (core_done && take) begin
      rsp_valid <= 1'b1;
      rsp_q     <= core_rsp;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  assign rsp.valid      = rsp_valid;
  assign rsp.hit        = rsp_q.hit;
  assign rsp.read_value = rsp_q.read_value;

  lkvc_core #(
    .MAX_ENTRIES(MAX_ENTRIES)
  ) u_core (
    .clk      (clk),
    .rst      (rst),
    .start    (req.valid && core_idle),
    .req_in   (core_req),
    .capacity (capacity),
    .take     (take),
    .idle     (core_idle),
    .done     (core_done),
    .rsp_out  (core_rsp)
  );

endmodule
`default_nettype wire

// ===== hdl/lkvc_check.sv =====
`default_nettype none
module lkvc_check (
  input wire logic                         clk,
  input wire logic                         rst,
  input wire logic                         req_valid,
  input wire logic                         req_ready,
  input wire logic                         rsp_valid,
  input wire logic                         rsp_ready,
  input wire logic                         rsp_hit,
  input wire logic [31:0]                  rsp_read_value,
  input wire logic                         psel,
  input wire logic                         penable,
  input wire logic                         pwrite,
  input wire logic [lkvc_pkg::PADDR_W-1:0] paddr,
  input wire logic [31:0]                  pwdata,
  input wire logic [31:0]                  prdata
);

  // one word in the core: busy right after a request is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while busy");

  // a miss always answers all ones
  a_miss_value: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_hit |-> rsp_read_value == 32'hFFFF_FFFF)
    else $error("miss with data");

  // stalled response holds
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_value) && $stable(rsp_hit))
    else $error("stalled response changed");

  // capacity reads back what was written
  a_cap_readback: assert property (@(posedge clk) disable iff (rst)
    (psel && penable && pwrite && paddr == '0) ##1 (paddr == '0)
      |-> prdata[4:0] == $past(pwdata[4:0]))
    else $error("capacity readback mismatch");

  // nothing presented right after reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("response valid after reset");

endmodule

bind lru_key_value_cache lkvc_check u_lkvc_check (
  .clk            (clk),
  .rst            (rst),
  .req_valid      (req.valid),
  .req_ready      (req.ready),
  .rsp_valid      (rsp.valid),
  .rsp_ready      (rsp.ready),
  .rsp_hit        (rsp.hit),
  .rsp_read_value (rsp.read_value),
  .psel           (psel),
  .penable        (penable),
  .pwrite         (pwrite),
  .paddr          (paddr),
  .pwdata         (pwdata),
  .prdata         (prdata)
);
`default_nettype wire

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps
module testbench;
  import lkvc_pkg::*;

  localparam int NSLOT = MAX_ENTRIES_DEF;
  // Worst case per word: scan, decide, rank sweep.
  localparam int LATENCY = 2 * NSLOT + 4;
  localparam int LONG_HOLD = 300;
  // Slowest correct run is about 700 words, each with core time, stall and
  // gap, plus a few long holds; this limit is several times that.
  localparam int unsigned CYCLE_LIMIT = 600_000;
  localparam int PHASES = 10;
  localparam int PHASE_WORDS = 65;

  typedef enum logic {ROW_WORD, ROW_CAP} row_kind_t;

  // One line of the directed plan. typed rows carry a hand-written result.
  typedef struct {
    row_kind_t  kind;
    req_t       word;
    bit         typed;
    rsp_t       want;
    logic [4:0] cap;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  lkvc_req_if req_bus ();
  lkvc_rsp_if rsp_bus ();

  lru_key_value_cache dut (
    .clk     (clk),
    .rst     (rst),
    .req     (req_bus),
    .rsp     (rsp_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------------
  // Cache shadow: keys, values, live bits, ages (0 = newest), fill count.
  // ---------------------------------------------------------------------
  logic [31:0] slot_key [NSLOT];
  logic [31:0] slot_val [NSLOT];
  bit          slot_live [NSLOT];
  int unsigned slot_age [NSLOT];
  int unsigned live_count;
  logic [4:0]  cap_shadow;

  rsp_t pending_rsp [$];   // results still owed by the block, oldest first
  int   fail_count = 0;

  // Hooks from the stimulus into the response side; set at a rising edge,
  // read at a falling edge.
  bit hold_request = 1'b0;
  bit steady = 1'b0;

  function automatic int unsigned capacity_limit(logic [4:0] c);
    if (c == 5'd0) return 1;
    if (c > NSLOT) return NSLOT;
    return c;
  endfunction

  // Slot s becomes newest; live slots younger than its old age get older.
  function automatic void make_newest(int s, int unsigned old_age);
    for (int i = 0; i < NSLOT; i++)
      if (i != s && slot_live[i] && slot_age[i] < old_age) slot_age[i]++;
    slot_age[s] = 0;
  endfunction

  // Applies one word to the shadow and returns the word the block owes.
  function automatic rsp_t cache_access(req_t w);
    int          found;
    int          slot;
    int unsigned oldest;
    rsp_t        r;
    found = -1;
    slot = -1;
    oldest = 0;
    for (int i = 0; i < NSLOT; i++)
      if (found < 0 && slot_live[i] && slot_key[i] == w.key) found = i;
    r.hit = (found >= 0);
    r.read_value = MISS_VALUE;
    if (w.command == CMD_GET) begin
      if (found >= 0) begin
        r.read_value = slot_val[found];
        make_newest(found, slot_age[found]);
      end
    end else if (found >= 0) begin
      slot_val[found] = w.value;
      make_newest(found, slot_age[found]);
    end else begin
      // full (or capacity lowered under the fill): reuse the oldest slot
      if (live_count >= capacity_limit(cap_shadow)) begin
        for (int i = 0; i < NSLOT; i++)
          if (slot_live[i] && (slot < 0 || slot_age[i] > oldest)) begin
            slot = i;
            oldest = slot_age[i];
          end
      end
      if (slot >= 0) begin
        slot_key[slot] = w.key;
        slot_val[slot] = w.value;
        make_newest(slot, slot_age[slot]);
      end else begin
        for (int i = 0; i < NSLOT; i++)
          if (slot < 0 && !slot_live[i]) slot = i;
        if (slot >= 0) begin
          slot_key[slot] = w.key;
          slot_val[slot] = w.value;
          make_newest(slot, NSLOT);
          slot_live[slot] = 1'b1;
          live_count++;
        end
      end
    end
    return r;
  endfunction

  function automatic void note_fail(string msg);
    fail_count++;
    if (fail_count <= 10) $display("%s", msg);
  endfunction

  // Mostly no gap, sometimes short ones, a few long ones.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // ---------------------------------------------------------------------
  // Plan rows
  // ---------------------------------------------------------------------
  function automatic plan_row_t word_row(logic cmd, logic [31:0] k, logic [31:0] v);
    plan_row_t r;
    r.kind = ROW_WORD;
    r.word = '{cmd, k, v};
    r.typed = 1'b0;
    r.want = '0;
    r.cap = '0;
    return r;
  endfunction

  function automatic plan_row_t known_row(logic cmd, logic [31:0] k, logic [31:0] v,
                                          logic h, logic [31:0] rd);
    plan_row_t r;
    r = word_row(cmd, k, v);
    r.typed = 1'b1;
    r.want = '{h, rd};
    return r;
  endfunction

  function automatic plan_row_t cap_row(logic [4:0] c);
    plan_row_t r;
    r = word_row(CMD_GET, '0, '0);
    r.kind = ROW_CAP;
    r.cap = c;
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------
  // Offer one word, hold it until taken, then log what it should produce.
  task automatic send_word(req_t w, bit typed, rsp_t want);
    rsp_t guess;
    @(negedge clk);
    req_bus.valid = 1'b1;
    req_bus.command = w.command;
    req_bus.key = w.key;
    req_bus.value = w.value;
    @(posedge clk);
    while (!req_bus.ready) @(posedge clk);
    guess = cache_access(w);
    pending_rsp.push_back(typed ? want : guess);
  endtask

  task automatic sender_pause(int n);
    if (n > 0) begin
      @(negedge clk);
      req_bus.valid = 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  // Stop offering and wait for every owed word; the block is idle after.
  task automatic drain();
    @(negedge clk);
    req_bus.valid = 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------
  // APB
  // ---------------------------------------------------------------------
  task automatic capacity_write(logic [31:0] data);
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {REG_CAPACITY, 2'b00};
    pwdata = data;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    cap_shadow = data[4:0];   // register keeps the low five bits
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  task automatic capacity_readback();
    @(negedge clk);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = {REG_CAPACITY, 2'b00};
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== {27'd0, cap_shadow})
      note_fail($sformatf("capacity readback: want %h got %h", {27'd0, cap_shadow}, prdata));
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
  endtask

  // ---------------------------------------------------------------------
  // Response side: random stalls, long hold on request, none when steady.
  // ---------------------------------------------------------------------
  initial begin : rsp_drive
    int stall;
    stall = 0;
    rsp_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        // block backs up: one word parked in rsp, one in the core
        rsp_bus.ready = 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        hold_request = 1'b0;
        rsp_bus.ready = 1'b1;
      end else if (stall > 0) begin
        rsp_bus.ready = 1'b0;
        stall--;
      end else begin
        rsp_bus.ready = 1'b1;
        if (!steady) stall = pick_gap();
      end
    end
  end

  always @(posedge clk) begin : rsp_check
    rsp_t want;
    if (!rst && rsp_bus.valid && rsp_bus.ready) begin
      if (pending_rsp.size() == 0) begin
        note_fail($sformatf("unexpected word: hit=%0b read_value=%h",
                            rsp_bus.hit, rsp_bus.read_value));
      end else begin
        want = pending_rsp.pop_front();
        if (rsp_bus.hit !== want.hit || rsp_bus.read_value !== want.read_value)
          note_fail($sformatf("mismatch: want hit=%0b read_value=%h, got hit=%0b read_value=%h",
                              want.hit, want.read_value, rsp_bus.hit, rsp_bus.read_value));
      end
    end
  end

  // Watchdog
  int unsigned cycle_count = 0;
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------
  initial begin : stimulus
    plan_row_t   plan [$];
    req_t        w;
    logic [31:0] data;
    logic [4:0]  cap;
    logic [31:0] base;
    int          pool;
    int          pick;

    req_bus.valid = 1'b0;
    req_bus.command = CMD_GET;
    req_bus.key = '0;
    req_bus.value = '0;
    live_count = 0;
    cap_shadow = CAPACITY_RESET;
    for (int i = 0; i < NSLOT; i++) begin
      slot_live[i] = 1'b0;
      slot_age[i] = 0;
      slot_key[i] = '0;
      slot_val[i] = '0;
    end

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    capacity_readback();   // reset value

    // Directed: empty store, extreme keys and values, set hit, value
    // ignored on a get, then capacity below the fill, zero and above max.
    plan = '{
      known_row(CMD_GET, 32'h0000_0000, 32'h0000_0000, 1'b0, MISS_VALUE),
      known_row(CMD_SET, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, MISS_VALUE),
      known_row(CMD_SET, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, MISS_VALUE),
      known_row(CMD_GET, 32'h8000_0000, 32'hFFFF_FFFF, 1'b1, 32'h7FFF_FFFF),
      known_row(CMD_GET, 32'h7FFF_FFFF, 32'h0000_0000, 1'b1, 32'h8000_0000),
      known_row(CMD_SET, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1, MISS_VALUE),
      known_row(CMD_GET, 32'h7FFF_FFFF, 32'h0000_0000, 1'b1, 32'hFFFF_FFFF),
      known_row(CMD_SET, 32'hFFFF_FFFF, 32'h0000_0000, 1'b0, MISS_VALUE),
      known_row(CMD_GET, 32'hFFFF_FFFF, 32'h1234_5678, 1'b1, 32'h0000_0000),
      known_row(CMD_GET, 32'h0000_0000, 32'hDEAD_BEEF, 1'b0, MISS_VALUE),
      known_row(CMD_SET, 32'h0000_0000, 32'h5555_5555, 1'b0, MISS_VALUE),
      known_row(CMD_GET, 32'h0000_0001, 32'h0000_0000, 1'b0, MISS_VALUE),
      cap_row(5'd2),         // four live entries, limit two
      word_row(CMD_SET, 32'h0000_0005, 32'hAAAA_AAAA),
      word_row(CMD_GET, 32'h8000_0000, 32'h0000_0000),
      word_row(CMD_GET, 32'h0000_0005, 32'h0000_0000),
      cap_row(5'd0),         // acts as one
      word_row(CMD_SET, 32'h0000_0006, 32'h0000_0006),
      word_row(CMD_GET, 32'h0000_0005, 32'h0000_0000),
      word_row(CMD_GET, 32'h0000_0006, 32'h0000_0000),
      cap_row(5'd31),        // clips to the slot count
      word_row(CMD_SET, 32'h0000_0007, 32'h0000_0007),
      word_row(CMD_GET, 32'hFFFF_FFFF, 32'h0000_0000),
      word_row(CMD_SET, 32'h0000_0000, 32'h0F0F_0F0F),
      cap_row(5'd16)
    };

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CAP) begin
        drain();
        capacity_write({27'd0, plan[i].cap});
        capacity_readback();
      end else begin
        send_word(plan[i].word, plan[i].typed, plan[i].want);
        sender_pause(pick_gap());
      end
    end

    // Random phases, one capacity each. Keys mostly from a pool a little
    // larger than the capacity so hits, updates and evictions all happen.
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: cap = 5'd1;
        1: cap = 5'd2;
        2: cap = 5'd16;
        3: cap = 5'd31;
        4: cap = 5'd0;
        5: cap = 5'd5;
        6: cap = 5'd17;
        7: cap = 5'd8;
        8: cap = 5'($urandom_range(0, 31));
        default: cap = 5'd16;
      endcase
      drain();
      data = $urandom();
      data[4:0] = cap;       // junk above the field
      capacity_write(data);
      capacity_readback();
      pool = capacity_limit(cap) + $urandom_range(1, 6);
      base = $urandom();

      @(posedge clk);
      steady = (p == 3 || p == 6);
      hold_request = (p == 2 || p == 7);

      for (int n = 0; n < PHASE_WORDS; n++) begin
        if (p == 5 && n == PHASE_WORDS / 2) drain();   // sender waits out the block
        w.command = $urandom_range(0, 1) ? CMD_SET : CMD_GET;
        pick = $urandom_range(0, 99);
        if (pick < 85) begin
          w.key = base + $urandom_range(0, pool - 1);
        end else if (pick < 93) begin
          w.key = $urandom();
        end else begin
          case ($urandom_range(0, 3))
            0: w.key = 32'h8000_0000;
            1: w.key = 32'h7FFF_FFFF;
            2: w.key = 32'h0000_0000;
            default: w.key = 32'hFFFF_FFFF;
          endcase
        end
        w.value = $urandom();
        send_word(w, 1'b0, '0);
        if (!steady) sender_pause(pick_gap());
      end
    end

    drain();
    repeat (LATENCY) @(posedge clk);   // room for a stray word to show up

    if (fail_count == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
